/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/pauct_pkg.sv */
// Shared types, codes and constants of the per-AP client table.
// Depends on nothing.
`timescale 1ns / 1ps
package pauct_pkg;

  localparam int AP_SLOTS_DEF       = 32;
  localparam int CLIENTS_PER_AP_DEF = 16;
  localparam int ADDR_W             = 48;
  localparam int LEN_W              = 12;
  localparam int FIELD_W            = 5;
  localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 12'd16;

  // Request actions.
  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_SHORT      = 3'd0;
  localparam logic [2:0] ST_SELF       = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_ADDED      = 3'd3;
  localparam logic [2:0] ST_DUPLICATE  = 3'd4;
  localparam logic [2:0] ST_LIST_FULL  = 3'd5;
  localparam logic [2:0] ST_QUERY      = 3'd6;
  localparam logic [2:0] ST_CLEARED    = 3'd7;

  // Index width of a store of n entries, at least one bit.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the request
    logic       clear;     // empty the table
    logic       scan_clr;  // restart the scan counter
    logic       kscan;     // scan access-point keys
    logic       lscan;     // scan the client list of the slot
    logic       cnt_cap;   // capture the slot's client count
    logic       claim;     // take the next free slot for the destination
    logic       add;       // append the source to the slot's list
    logic       res_load;  // load the output register
    logic [2:0] res_code;
    logic       res_cnt;   // report count and slot instead of zeros
  } pauct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       short_frame;
    logic       self_addr;
    logic       table_full;
    logic       list_full;
    logic       hit;
    logic       scan_end;
    logic       out_free;
  } pauct_stat_t;

endpackage

/* hdl/pauct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on pauct_pkg.
`timescale 1ns / 1ps
module pauct_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [pauct_pkg::idx_w(DEPTH)-1:0]    waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [pauct_pkg::idx_w(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]                      rdata
);
  import pauct_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pauct_datapath.sv */
// Datapath of the per-AP client table: request registers, key, count and
// client memories, scan counter and output register. Depends on pauct_pkg, pauct_ram.
`timescale 1ns / 1ps
module pauct_datapath #(
  parameter int AP_SLOTS       = pauct_pkg::AP_SLOTS_DEF,
  parameter int CLIENTS_PER_AP = pauct_pkg::CLIENTS_PER_AP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pauct_pkg::pauct_cmd_t         cmd,
  output pauct_pkg::pauct_stat_t        stat,
  input  logic [1:0]                    action,
  input  logic [pauct_pkg::LEN_W-1:0]   frame_length,
  input  logic [pauct_pkg::ADDR_W-1:0]  dest_addr,
  input  logic [pauct_pkg::ADDR_W-1:0]  src_addr,
  input  logic [pauct_pkg::ADDR_W-1:0]  query_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [pauct_pkg::FIELD_W-1:0] client_total,
  output logic [pauct_pkg::FIELD_W-1:0] entry_slot
);
  import pauct_pkg::*;

  localparam int SW   = idx_w(AP_SLOTS);
  localparam int CW   = idx_w(CLIENTS_PER_AP);
  localparam int UW   = $clog2(AP_SLOTS + 1);
  localparam int NW   = $clog2(CLIENTS_PER_AP + 1);
  localparam int MAXN = (AP_SLOTS > CLIENTS_PER_AP) ? AP_SLOTS : CLIENTS_PER_AP;
  localparam int XW   = $clog2(MAXN + 1);
  localparam int STORE_DEPTH = AP_SLOTS * CLIENTS_PER_AP;
  localparam int AW   = idx_w(STORE_DEPTH);

  logic [1:0]        act;
  logic [LEN_W-1:0]  flen;
  logic [ADDR_W-1:0] dst;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] qry;
  logic [UW-1:0]     used;
  logic [SW-1:0]     slot;
  logic [NW-1:0]     cnt;
  logic [XW-1:0]     idx;
  logic [XW-1:0]     pidx;
  logic              pend;

  logic [ADDR_W-1:0] key_rdata;
  logic [ADDR_W-1:0] cli_rdata;
  logic [NW-1:0]     cnt_rdata;
  logic [ADDR_W-1:0] key;
  logic [XW-1:0]     limit;
  logic              hit;
  logic              more;
  logic [AW-1:0]     store_raddr;
  logic [AW-1:0]     store_waddr;
  logic [NW-1:0]     cnt_inc;
  logic [31:0]       cnt_wide;
  logic [31:0]       slot_wide;

  // Key compared during the key scan: destination for frames, else query.
  assign key     = (act == ACT_FRAME) ? dst : qry;
  assign limit   = cmd.kscan ? XW'(used) : XW'(cnt);
  assign hit     = pend && (cmd.kscan ? (key_rdata == key) : (cli_rdata == src));
  assign more    = idx < limit;
  assign cnt_inc = cnt + NW'(1);

  // Client store address is slot times list length plus list index.
  assign store_raddr = AW'(AW'(slot) * AW'(CLIENTS_PER_AP)) + AW'(idx[CW-1:0]);
  assign store_waddr = AW'(AW'(slot) * AW'(CLIENTS_PER_AP)) + AW'(cnt[CW-1:0]);

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action;
      flen <= frame_length;
      dst  <= dest_addr;
      src  <= src_addr;
      qry  <= query_addr;
    end
  end

  // Table fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.clear) begin
      used <= '0;
    end else if (cmd.claim) begin
      used <= used + UW'(1);
    end
  end

  // Slot and client count of the entry in work.
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      slot <= used[SW-1:0];
      cnt  <= '0;
    end else if (cmd.kscan && hit) begin
      slot <= pidx[SW-1:0];
    end else if (cmd.cnt_cap) begin
      cnt <= cnt_rdata;
    end else if (cmd.add) begin
      cnt <= cnt_inc;
    end
  end

  // Scan counter: issue one read a cycle, compare the data in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      idx  <= '0;
      pidx <= '0;
    end else if (cmd.scan_clr) begin
      pend <= 1'b0;
      idx  <= '0;
    end else if ((cmd.kscan || cmd.lscan) && !hit) begin
      pend <= more;
      pidx <= idx;
      if (more) begin
        idx <= idx + XW'(1);
      end
    end
  end

  pauct_ram #(.WIDTH(ADDR_W), .DEPTH(AP_SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.claim),
    .waddr (used[SW-1:0]),
    .wdata (dst),
    .raddr (idx[SW-1:0]),
    .rdata (key_rdata)
  );

  pauct_ram #(.WIDTH(NW), .DEPTH(AP_SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.add),
    .waddr (slot),
    .wdata (cnt_inc),
    .raddr (slot),
    .rdata (cnt_rdata)
  );

  pauct_ram #(.WIDTH(ADDR_W), .DEPTH(STORE_DEPTH)) u_store_ram (
    .clk   (clk),
    .we    (cmd.add),
    .waddr (store_waddr),
    .wdata (src),
    .raddr (store_raddr),
    .rdata (cli_rdata)
  );

  // Output register; fields are cut to the result width.
  assign cnt_wide  = 32'(cnt);
  assign slot_wide = 32'(slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status       <= cmd.res_code;
      client_total <= cmd.res_cnt ? cnt_wide[FIELD_W-1:0] : '0;
      entry_slot   <= cmd.res_cnt ? slot_wide[FIELD_W-1:0] : '0;
    end
  end

  // Status toward the controller.
  assign stat.action      = act;
  assign stat.short_frame = flen < MIN_FRAME_BYTES;
  assign stat.self_addr   = dst == src;
  assign stat.table_full  = used >= UW'(AP_SLOTS);
  assign stat.list_full   = cnt >= NW'(CLIENTS_PER_AP);
  assign stat.hit         = hit;
  assign stat.scan_end    = !hit && !more;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

/* hdl/pauct_ctrl.sv */
// Controller state machine of the per-AP client table.
// Depends on pauct_pkg.
`timescale 1ns / 1ps
module pauct_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pauct_pkg::pauct_stat_t stat,
  output pauct_pkg::pauct_cmd_t  cmd
);
  import pauct_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_KSCAN  = 4'd2;
  localparam logic [3:0] S_CREQ   = 4'd3;
  localparam logic [3:0] S_CWAIT  = 4'd4;
  localparam logic [3:0] S_LSCAN  = 4'd5;
  localparam logic [3:0] S_ADD    = 4'd6;
  localparam logic [3:0] S_RES    = 4'd7;

  logic [3:0] state, state_next;
  logic [2:0] rcode, rcode_next;
  logic       rcnt, rcnt_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rcode <= ST_SHORT;
      rcnt  <= 1'b0;
    end else begin
      state <= state_next;
      rcode <= rcode_next;
      rcnt  <= rcnt_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    rcode_next   = rcode;
    rcnt_next    = rcnt;
    cmd          = '0;
    cmd.res_code = rcode;
    cmd.res_cnt  = rcnt;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_clr = 1'b1;
        rcnt_next    = 1'b0;
        state_next   = S_RES;
        case (stat.action)
          ACT_FRAME: begin
            if (stat.short_frame) begin
              rcode_next = ST_SHORT;
            end else if (stat.self_addr) begin
              rcode_next = ST_SELF;
            end else begin
              state_next = S_KSCAN;
            end
          end
          ACT_QUERY: begin
            state_next = S_KSCAN;
          end
          ACT_CLEAR: begin
            cmd.clear  = 1'b1;
            rcode_next = ST_CLEARED;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_KSCAN: begin
        cmd.kscan = 1'b1;
        if (stat.hit) begin
          state_next = S_CREQ;
        end else if (stat.scan_end) begin
          rcnt_next = 1'b0;
          if (stat.action == ACT_QUERY) begin
            rcode_next = ST_QUERY;
            state_next = S_RES;
          end else if (stat.table_full) begin
            rcode_next = ST_TABLE_FULL;
            state_next = S_RES;
          end else begin
            cmd.claim  = 1'b1;
            state_next = S_ADD;
          end
        end
      end
      S_CREQ: begin
        state_next = S_CWAIT;
      end
      S_CWAIT: begin
        cmd.cnt_cap  = 1'b1;
        cmd.scan_clr = 1'b1;
        rcnt_next    = 1'b1;
        if (stat.action == ACT_QUERY) begin
          rcode_next = ST_QUERY;
          state_next = S_RES;
        end else begin
          state_next = S_LSCAN;
        end
      end
      S_LSCAN: begin
        cmd.lscan = 1'b1;
        if (stat.hit) begin
          rcode_next = ST_DUPLICATE;
          state_next = S_RES;
        end else if (stat.scan_end) begin
          if (stat.list_full) begin
            rcode_next = ST_LIST_FULL;
            state_next = S_RES;
          end else begin
            state_next = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        rcode_next = ST_ADDED;
        rcnt_next  = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/per_ap_unique_client_table.sv */
// Top level of the per-AP client table: controller plus datapath.
// Depends on pauct_pkg, pauct_ctrl, pauct_datapath.
`timescale 1ns / 1ps
// Each request gives one result, except action 3, which is dropped. One request
// is in work at a time. Short, self-addressed and clear requests go from the
// decode state straight to the result state. A lookup scans the stored keys one
// per cycle until the key is found or the entries in use are all read. A found
// key then fetches its client count through the request and wait states, and a
// frame then scans the client list one per cycle and appends a new client in
// the add state. A finished result sits in an output register, so the next
// request is taken while it waits.
module per_ap_unique_client_table #(
  parameter int AP_SLOTS       = pauct_pkg::AP_SLOTS_DEF,
  parameter int CLIENTS_PER_AP = pauct_pkg::CLIENTS_PER_AP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [pauct_pkg::LEN_W-1:0]   frame_length,
  input  logic [pauct_pkg::ADDR_W-1:0]  dest_addr,
  input  logic [pauct_pkg::ADDR_W-1:0]  src_addr,
  input  logic [pauct_pkg::ADDR_W-1:0]  query_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [pauct_pkg::FIELD_W-1:0] client_total,
  output logic [pauct_pkg::FIELD_W-1:0] entry_slot
);
  import pauct_pkg::*;

  pauct_cmd_t  cmd;
  pauct_stat_t stat;

  pauct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pauct_datapath #(
    .AP_SLOTS       (AP_SLOTS),
    .CLIENTS_PER_AP (CLIENTS_PER_AP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .frame_length (frame_length),
    .dest_addr    (dest_addr),
    .src_addr     (src_addr),
    .query_addr   (query_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .client_total (client_total),
    .entry_slot   (entry_slot)
  );

endmodule

/* hdl/pauct_checker.sv */
// Port-level checks of the per-AP client table, bound to the top level.
// Depends on pauct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pauct_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [4:0] client_total,
  input logic [4:0] entry_slot
);
  import pauct_pkg::*;

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // One request at a time: after an accept the input side closes.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // Results that touch no entry report zeros.
  `ASSERT_SAME(a_zero_fields, clk, rst,
    out_valid && (status == ST_SHORT || status == ST_SELF ||
    status == ST_TABLE_FULL || status == ST_CLEARED),
    client_total == '0 && entry_slot == '0)

  // An added client always leaves a nonzero count.
  `ASSERT_SAME(a_added_count, clk, rst, out_valid && status == ST_ADDED,
    client_total != '0)

endmodule

bind per_ap_unique_client_table pauct_checker u_pauct_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .client_total (client_total),
  .entry_slot   (entry_slot)
);

/* bench/per_ap_unique_client_table_test.sv */
// Self-checking bench for the per-AP unique client table.
// Depends on pauct_pkg and per_ap_unique_client_table; predicts each result itself.
`timescale 1ns / 1ps
module per_ap_unique_client_table_test;
  import pauct_pkg::*;

  localparam int SLOTS = AP_SLOTS_DEF;
  localparam int CLIENTS = CLIENTS_PER_AP_DEF;
  localparam int IDLE_LIMIT = 20000;
  // Action value with no meaning; the block drops it.
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_FRAME;
  logic [LEN_W-1:0] frame_length = '0;
  logic [ADDR_W-1:0] dest_addr = '0;
  logic [ADDR_W-1:0] src_addr = '0;
  logic [ADDR_W-1:0] query_addr = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [FIELD_W-1:0] client_total;
  logic [FIELD_W-1:0] entry_slot;

  typedef struct packed {
    logic [2:0] status;
    logic [FIELD_W-1:0] total;
    logic [FIELD_W-1:0] slot;
  } table_result_t;

  // Predicted table contents.
  logic [ADDR_W-1:0] ap_tab [SLOTS];
  int ap_count;
  int client_cnt [SLOTS];
  logic [ADDR_W-1:0] client_tab [SLOTS][CLIENTS];

  table_result_t pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  logic [ADDR_W-1:0] ap_pool [8];
  logic [ADDR_W-1:0] cl_pool [24];

  always #4 clk = ~clk;

  per_ap_unique_client_table u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .frame_length(frame_length), .dest_addr(dest_addr),
    .src_addr(src_addr), .query_addr(query_addr), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .client_total(client_total),
    .entry_slot(entry_slot)
  );

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic int lookup_ap(logic [ADDR_W-1:0] key);
    for (int i = 0; i < ap_count; i++)
      if (ap_tab[i] == key) return i;
    return -1;
  endfunction

  // Compute the expected result of one request and update the table copy.
  function automatic bit predict_table(logic [1:0] act, logic [LEN_W-1:0] flen,
      logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] qry,
      output table_result_t res);
    int s;
    res = '0;
    case (act)
      ACT_FRAME: begin
        if (flen < MIN_FRAME_BYTES) begin
          res.status = ST_SHORT;
          return 1;
        end
        if (dst == src) begin
          res.status = ST_SELF;
          return 1;
        end
        s = lookup_ap(dst);
        if (s < 0) begin
          if (ap_count >= SLOTS) begin
            res.status = ST_TABLE_FULL;
            return 1;
          end
          s = ap_count;
          ap_count++;
          ap_tab[s] = dst;
          client_cnt[s] = 0;
        end
        res.slot = s[FIELD_W-1:0];
        for (int j = 0; j < client_cnt[s]; j++)
          if (client_tab[s][j] == src) begin
            res.status = ST_DUPLICATE;
            res.total = client_cnt[s][FIELD_W-1:0];
            return 1;
          end
        if (client_cnt[s] >= CLIENTS) begin
          res.status = ST_LIST_FULL;
          res.total = client_cnt[s][FIELD_W-1:0];
          return 1;
        end
        client_tab[s][client_cnt[s]] = src;
        client_cnt[s]++;
        res.status = ST_ADDED;
        res.total = client_cnt[s][FIELD_W-1:0];
        return 1;
      end
      ACT_QUERY: begin
        res.status = ST_QUERY;
        s = lookup_ap(qry);
        if (s >= 0) begin
          res.total = client_cnt[s][FIELD_W-1:0];
          res.slot = s[FIELD_W-1:0];
        end
        return 1;
      end
      ACT_CLEAR: begin
        ap_count = 0;
        res.status = ST_CLEARED;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Send one request, predicting its result, and hold it until accepted.
  task automatic send_request(logic [1:0] act, logic [LEN_W-1:0] flen,
      logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] qry);
    table_result_t res;
    if (predict_table(act, flen, dst, src, qry, res)) pending_results.push_back(res);
    in_valid <= 1'b1;
    action <= act;
    frame_length <= flen;
    dest_addr <= dst;
    src_addr <= src;
    query_addr <= qry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Drop valid and wait a random gap; called only between bursts.
  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 6);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic burst_point();
    if ($urandom_range(0, 5) == 0) sender_gap();
  endtask

  task automatic frame_to(logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src);
    send_request(ACT_FRAME, LEN_W'($urandom_range(16, 4095)), dst, src, rand_addr());
  endtask

  // Field extremes, every action, short and self-addressed frames.
  task automatic test_basic_actions();
    send_request(ACT_QUERY, 0, 0, 0, '1);
    send_request(ACT_FRAME, 0, '1, 0, 0);
    send_request(ACT_FRAME, 15, '1, 0, 0);
    send_request(ACT_FRAME, 16, '1, '1, 0);
    send_request(ACT_FRAME, 16, '1, 0, 0);
    send_request(ACT_FRAME, '1, 0, '1, '1);
    send_request(ACT_FRAME, '1, '1, 0, '1);
    send_request(ACT_FRAME, '1, '1, '1 - 1, 0);
    send_request(ACT_QUERY, 0, 0, 0, '1);
    send_request(ACT_QUERY, 0, 0, 0, 0);
    send_request(ACT_UNDEF, '1, '1, '1, '1);
    send_request(ACT_CLEAR, 0, 0, 0, 0);
    send_request(ACT_QUERY, 0, 0, 0, '1);
    sender_gap();
  endtask

  // Overfill one client list and the whole table.
  task automatic test_capacity();
    logic [ADDR_W-1:0] ap;
    ap = rand_addr();
    for (int j = 0; j < CLIENTS + 2; j++) frame_to(ap, 48'h100 + j);
    frame_to(ap, 48'h100);
    send_request(ACT_QUERY, 0, 0, 0, ap);
    for (int i = 1; i < SLOTS + 2; i++) begin
      frame_to(48'hA0_0000 + i, 48'h55);
      burst_point();
    end
    send_request(ACT_QUERY, 0, 0, 0, 48'hA0_0000 + SLOTS - 1);
    send_request(ACT_CLEAR, 0, 0, 0, 0);
    sender_gap();
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) frame_to(ap_pool[i % 3], cl_pool[i]);
    sender_gap();
  endtask

  // Mostly frames drawn from small address pools so entries fill and repeat.
  task automatic test_random_traffic(int count);
    int r;
    logic [1:0] act;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        frame_to(ap_pool[$urandom_range(0, 7)], cl_pool[$urandom_range(0, 23)]);
      end else if (r < 76) begin
        send_request(ACT_FRAME, LEN_W'($urandom_range(0, 4095)), rand_addr(),
                     rand_addr(), rand_addr());
      end else if (r < 79) begin
        frame_to(ap_pool[$urandom_range(0, 7)], ap_pool[$urandom_range(0, 7)]);
      end else if (r < 81) begin
        frame_to(rand_addr(), rand_addr());
      end else if (r < 94) begin
        send_request(ACT_QUERY, LEN_W'($urandom), rand_addr(), rand_addr(),
                     ($urandom_range(0, 3) == 0) ? rand_addr()
                                                 : ap_pool[$urandom_range(0, 7)]);
      end else begin
        act = (r < 97) ? ACT_CLEAR : ACT_UNDEF;
        send_request(act, LEN_W'($urandom), rand_addr(), rand_addr(), rand_addr());
      end
      burst_point();
    end
    in_valid <= 1'b0;
  endtask

  // Receiver stall pattern, with a long hold-off when requested.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 3);
      if (n == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", status);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status || client_total !== exp_r.total ||
            entry_slot !== exp_r.slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d tot=%0d slot=%0d got st=%0d tot=%0d slot=%0d",
                     exp_r.status, exp_r.total, exp_r.slot,
                     status, client_total, entry_slot);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) ap_pool[i] = rand_addr();
    for (int i = 0; i < 24; i++) cl_pool[i] = rand_addr();
    ap_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_actions();
    test_capacity();
    test_backpressure();
    test_random_traffic(1000);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests and checked %0d results, covering every status,",
             requests_sent, results_seen);
    $display("full lists, a full table, clears and a long receiver stall.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/pauct_pkg.sv
hdl/pauct_ram.sv
hdl/pauct_datapath.sv
hdl/pauct_ctrl.sv
hdl/per_ap_unique_client_table.sv
hdl/pauct_checker.sv
bench/per_ap_unique_client_table_test.sv
